>>> src/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while rst is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, skipped while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> src/eats_pkg.sv
// Types and constants for the energy-aware task scheduler
package eats_pkg;

   localparam int SLOTS      = 4;
   localparam int TASK_IDS   = 4;
   localparam int SLOT_W     = 2;
   localparam int TASK_W     = 2;
   localparam int THR_W      = 13;
   localparam int DUR_W      = 16;
   localparam int VOLT_W     = 13;
   localparam int PWR_W      = 20;
   localparam int CNT_W      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [PWR_W-1:0] PWR_THR_RESET   = '1;
   localparam logic [CNT_W-1:0] TASK_CNT_RESET  = 3'd1;

   localparam logic [CSR_ADDR_W-1:0] CSR_POWER_THR  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TASK_COUNT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOT0      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOT1      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOT2      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOT3      = 3'd5;

   // Matches the register packing: duration 30:15, task id 14:13, threshold 12:0
   typedef struct packed {
      logic [DUR_W-1:0]  dur;
      logic [TASK_W-1:0] task_id;
      logic [THR_W-1:0]  thr;
   } slot_entry_type;

   typedef struct packed {
      logic [PWR_W-1:0]                 pwr_thr;
      logic [CNT_W-1:0]                 eff_count;
      slot_entry_type [SLOTS-1:0]       slots;
   } cfg_type;

   typedef struct packed {
      logic              task_started;
      logic              task_finished;
      logic [TASK_W-1:0] active_task;
      logic              busy_res;
      logic              next_valid;
      logic [SLOT_W-1:0] next_slot;
   } result_type;

endpackage

>>> src/energy_aware_task_scheduler.sv
// Top level: register file, input register, result register, scheduler core
// Each req item is one scheduler tick. An item is taken into an input register, evaluated
// by the core (start/finish of the running task, saturating execution counts,
// next-slot choice) and written to a result register when that register is free or draining,
// so one item per cycle is sustained while rsp_stall is low; the limit is the state update
// loop through the execution counts and the slot choice. The input side keeps taking
// items while a result waits under rsp_stall until the input register is also full.
// Configuration writes take effect at the next edge and are expected only while no item
// is in flight.
module energy_aware_task_scheduler #(
   parameter int COUNT_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [eats_pkg::VOLT_W-1:0]     req_buffer_voltage_mv,
   input  logic [eats_pkg::PWR_W-1:0]      req_harvest_power_uw,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_task_started,
   output logic                            rsp_task_finished,
   output logic [eats_pkg::TASK_W-1:0]     rsp_active_task,
   output logic                            rsp_busy_res,
   output logic                            rsp_next_valid,
   output logic [eats_pkg::SLOT_W-1:0]     rsp_next_slot,
   input  logic                            csr_write_enable,
   input  logic [eats_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [eats_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import eats_pkg::*;

   logic [PWR_W-1:0]           pwr_thr_ff, pwr_thr_in;
   logic [CNT_W-1:0]           task_cnt_ff, task_cnt_in;
   slot_entry_type [SLOTS-1:0] slot_ff, slot_in;
   cfg_type                    cfg;

   logic                       in_valid_ff, in_valid_in;
   logic [VOLT_W-1:0]          in_volt_ff;
   logic [PWR_W-1:0]           in_pwr_ff;
   logic                       out_valid_ff, out_valid_in;
   result_type                 out_res_ff;
   result_type                 core_res;
   logic                       accept, advance;

   // register writes
   always_comb begin
      pwr_thr_in  = pwr_thr_ff;
      task_cnt_in = task_cnt_ff;
      slot_in     = slot_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_POWER_THR:  pwr_thr_in  = csr_write_data[PWR_W-1:0];
            CSR_TASK_COUNT: task_cnt_in = csr_write_data[CNT_W-1:0];
            CSR_SLOT0:      slot_in[0]  = slot_entry_type'(csr_write_data);
            CSR_SLOT1:      slot_in[1]  = slot_entry_type'(csr_write_data);
            CSR_SLOT2:      slot_in[2]  = slot_entry_type'(csr_write_data);
            CSR_SLOT3:      slot_in[3]  = slot_entry_type'(csr_write_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwr_thr_ff  <= PWR_THR_RESET;
         task_cnt_ff <= TASK_CNT_RESET;
         slot_ff     <= '0;
      end else begin
         pwr_thr_ff  <= pwr_thr_in;
         task_cnt_ff <= task_cnt_in;
         slot_ff     <= slot_in;
      end
   end

   // zero counts as one task, anything above the slot count as all slots
   always_comb begin
      cfg.pwr_thr = pwr_thr_ff;
      cfg.slots   = slot_ff;
      if (task_cnt_ff == '0) begin
         cfg.eff_count = CNT_W'(1);
      end else if (task_cnt_ff > CNT_W'(SLOTS)) begin
         cfg.eff_count = CNT_W'(SLOTS);
      end else begin
         cfg.eff_count = task_cnt_ff;
      end
   end

   // handshake: input register drains whenever the result register is free
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_volt_ff <= req_buffer_voltage_mv;
         in_pwr_ff  <= req_harvest_power_uw;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   eats_core #(.COUNT_BITS(COUNT_BITS)) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .volt   (in_volt_ff),
      .pwr    (in_pwr_ff),
      .result (core_res)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_task_started  = out_res_ff.task_started;
   assign rsp_task_finished = out_res_ff.task_finished;
   assign rsp_active_task   = out_res_ff.active_task;
   assign rsp_busy_res      = out_res_ff.busy_res;
   assign rsp_next_valid    = out_res_ff.next_valid;
   assign rsp_next_slot     = out_res_ff.next_slot;

endmodule

>>> src/eats_select.sv
// Next-slot choice from thresholds, task enables and harvested power
module eats_select #(
   parameter int COUNT_BITS = 32
) (
   input  eats_pkg::cfg_type                  cfg,
   input  logic [COUNT_BITS-1:0]              counts [eats_pkg::TASK_IDS],
   input  logic [eats_pkg::VOLT_W-1:0]        volt,
   input  logic [eats_pkg::PWR_W-1:0]         pwr,
   output logic                               next_valid,
   output logic [eats_pkg::SLOT_W-1:0]        next_slot
);
   import eats_pkg::*;

   logic [TASK_IDS-1:0] task_en;
   logic [SLOTS-1:0]    slot_en;
   logic [SLOTS-1:0]    cand;
   logic                found;

   always_comb begin
      // count is clamped to at least one, so task 0 is always in range
      task_en[0] = 1'b1;
      for (int t = 1; t < TASK_IDS; t++) begin
         task_en[t] = (CNT_W'(t) < cfg.eff_count) && (counts[t-1] > counts[t]);
      end
      for (int s = 0; s < SLOTS; s++) begin
         slot_en[s] = (CNT_W'(s) < cfg.eff_count) && task_en[cfg.slots[s].task_id];
         cand[s]    = slot_en[s] && (volt > cfg.slots[s].thr);
      end
   end

   always_comb begin
      next_valid = 1'b0;
      next_slot  = '0;
      found      = 1'b0;
      if (cand[0]) begin
         next_valid = 1'b1;
      end else if (!(slot_en[0] && (pwr > cfg.pwr_thr))) begin
         for (int s = SLOTS - 1; s > 0; s--) begin
            if (cand[s] && !found) begin
               found      = 1'b1;
               next_valid = 1'b1;
               next_slot  = SLOT_W'(s);
            end
         end
      end
   end

endmodule

>>> src/eats_core.sv
// Scheduler state: running task, tick counter, execution counts, chosen slot
module eats_core #(
   parameter int COUNT_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  eats_pkg::cfg_type           cfg,
   input  logic [eats_pkg::VOLT_W-1:0] volt,
   input  logic [eats_pkg::PWR_W-1:0]  pwr,
   output eats_pkg::result_type        result
);
   import eats_pkg::*;

   logic                  run_ff, run_in;
   logic [SLOT_W-1:0]     rslot_ff, rslot_in;
   logic [DUR_W-1:0]      elapsed_ff, elapsed_in, elapsed_inc;
   logic [COUNT_BITS-1:0] count_ff [TASK_IDS];
   logic [COUNT_BITS-1:0] count_in [TASK_IDS];
   logic                  chosen_valid_ff, chosen_valid_in;
   logic [SLOT_W-1:0]     chosen_slot_ff, chosen_slot_in;
   logic [TASK_W-1:0]     run_task, start_task;
   logic                  sel_valid;
   logic [SLOT_W-1:0]     sel_slot;

   assign run_task   = cfg.slots[rslot_ff].task_id;
   assign start_task = cfg.slots[chosen_slot_ff].task_id;

   always_comb begin
      run_in      = run_ff;
      rslot_in    = rslot_ff;
      elapsed_in  = elapsed_ff;
      count_in    = count_ff;
      result      = '0;
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
      if (!run_ff) begin
         elapsed_in = '0;
         if (chosen_valid_ff) begin
            run_in              = 1'b1;
            rslot_in            = chosen_slot_ff;
            result.task_started = 1'b1;
            result.active_task  = start_task;
         end
      end else begin
         result.active_task = run_task;
         elapsed_in         = elapsed_inc;
         if (elapsed_inc >= cfg.slots[rslot_ff].dur) begin
            if (count_ff[run_task] != '1) begin
               count_in[run_task] = count_ff[run_task] + 1'b1;
            end
            result.task_finished = 1'b1;
            run_in               = 1'b0;
         end
      end
      chosen_valid_in   = sel_valid;
      chosen_slot_in    = sel_slot;
      result.busy_res   = run_in;
      result.next_valid = sel_valid;
      result.next_slot  = sel_slot;
   end

   // choice is made on the counts as updated by this tick
   eats_select #(.COUNT_BITS(COUNT_BITS)) u_select (
      .cfg        (cfg),
      .counts     (count_in),
      .volt       (volt),
      .pwr        (pwr),
      .next_valid (sel_valid),
      .next_slot  (sel_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff          <= 1'b0;
         rslot_ff        <= '0;
         elapsed_ff      <= '0;
         chosen_valid_ff <= 1'b0;
         chosen_slot_ff  <= '0;
         for (int t = 0; t < TASK_IDS; t++) begin
            count_ff[t] <= '0;
         end
      end else if (step) begin
         run_ff          <= run_in;
         rslot_ff        <= rslot_in;
         elapsed_ff      <= elapsed_in;
         chosen_valid_ff <= chosen_valid_in;
         chosen_slot_ff  <= chosen_slot_in;
         count_ff        <= count_in;
      end
   end

endmodule

>>> src/eats_checker.sv
// Port-level checks for the scheduler and their bind to the top level
`include "assert_macros.svh"

module eats_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_task_started,
   input logic                            rsp_task_finished,
   input logic [eats_pkg::TASK_W-1:0]     rsp_active_task,
   input logic                            rsp_busy_res,
   input logic                            rsp_next_valid,
   input logic [eats_pkg::SLOT_W-1:0]     rsp_next_slot
);

   // nothing shows on the result side the edge after reset
   `ASSERT_IMPLIES(a_reset_clears, clock, 1'b0, $past(reset), !rsp_valid)

   // with the result register empty the input side never stalls
   `ASSERT_IMPLIES(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // an accepted item passes the input register and reaches the result register when not held
   `ASSERT_NEXT(a_item_reaches_out, clock, reset,
      (req_valid && !req_stall) ##1 (!rsp_stall && !reset), rsp_valid)

   // a held result stays put
   `ASSERT_NEXT(a_out_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_task_started) && $stable(rsp_task_finished) &&
      $stable(rsp_active_task) && $stable(rsp_busy_res) &&
      $stable(rsp_next_valid) && $stable(rsp_next_slot))

endmodule

bind energy_aware_task_scheduler eats_checker u_eats_checker (.*);

>>> bench/testbench.sv
// Testbench for the energy-aware task scheduler: tick stimulus, scheduling predictor, checks
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import eats_pkg::*;

   localparam int COUNT_W     = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_TICKS = 112;

   // Indexes past the end of the register list; writes to them must be ignored
   localparam logic [CSR_ADDR_W-1:0] CSR_PAST_END_A = CSR_SLOT3 + 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAST_END_B = CSR_SLOT3 + 3'd2;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_TOGGLE} stall_mode_type;

   class schedule_tracker_type;
      // register copies
      logic [PWR_W-1:0] pwr_thr;
      logic [CNT_W-1:0] cnt_raw;
      slot_entry_type   slots [SLOTS];
      // scheduler state
      bit               busy;
      logic [SLOT_W-1:0] run_slot;
      logic [DUR_W-1:0]  ticks;
      logic [COUNT_W-1:0] runs [TASK_IDS];
      bit                have_pick;
      logic [SLOT_W-1:0] pick_slot;

      result_type pending_decisions [$];
      int errors, tick_total, starts, finishes, holds;
      int picks [SLOTS];

      function new();
         pwr_thr   = PWR_THR_RESET;
         cnt_raw   = TASK_CNT_RESET;
         busy      = 0;
         run_slot  = '0;
         ticks     = '0;
         have_pick = 0;
         pick_slot = '0;
         for (int i = 0; i < SLOTS; i++) begin
            slots[i] = '0;
            picks[i] = 0;
         end
         for (int i = 0; i < TASK_IDS; i++) runs[i] = '0;
         errors = 0; tick_total = 0; starts = 0; finishes = 0; holds = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_POWER_THR:  pwr_thr = data[PWR_W-1:0];
            CSR_TASK_COUNT: cnt_raw = data[CNT_W-1:0];
            CSR_SLOT0:      slots[0] = data;
            CSR_SLOT1:      slots[1] = data;
            CSR_SLOT2:      slots[2] = data;
            CSR_SLOT3:      slots[3] = data;
            default: ;
         endcase
      endfunction

      function bit eligible(int s);
         int n;
         int t;
         n = int'(cnt_raw);
         if (n < 1) n = 1;
         if (n > SLOTS) n = SLOTS;
         if (s >= n) return 0;
         t = int'(slots[s].task_id);
         if (t >= n) return 0;
         if (t == 0) return 1;
         return runs[t-1] > runs[t];
      endfunction

      function int pending();
         return pending_decisions.size();
      endfunction

      // One tick: start or advance the running task, then choose the next slot
      function void note_tick(logic [VOLT_W-1:0] volt, logic [PWR_W-1:0] pwr);
         result_type r;
         logic [TASK_W-1:0] t;
         r = '0;
         tick_total++;
         if (!busy) begin
            if (have_pick) begin
               busy = 1;
               run_slot = pick_slot;
               r.task_started = 1'b1;
               r.active_task = slots[run_slot].task_id;
               starts++;
            end
            ticks = '0;
         end else begin
            t = slots[run_slot].task_id;
            r.active_task = t;
            if (ticks != '1) ticks = ticks + 1'b1;
            if (ticks >= slots[run_slot].dur) begin
               if (runs[t] != '1) runs[t] = runs[t] + 1'b1;
               r.task_finished = 1'b1;
               busy = 0;
               finishes++;
            end
         end

         have_pick = 0;
         pick_slot = '0;
         if (eligible(0) && volt > slots[0].thr) begin
            have_pick = 1;
         end else if (eligible(0) && pwr > pwr_thr) begin
            holds++;
         end else begin
            for (int s = SLOTS - 1; s > 0 && !have_pick; s--) begin
               if (eligible(s) && volt > slots[s].thr) begin
                  have_pick = 1;
                  pick_slot = s[SLOT_W-1:0];
               end
            end
         end
         if (have_pick) picks[pick_slot]++;

         r.busy_res   = busy;
         r.next_valid = have_pick;
         r.next_slot  = pick_slot;
         pending_decisions.insert(pending_decisions.size(), r);
      endfunction

      function void report(string what, result_type want, result_type got);
         errors++;
         if (errors <= 10) begin
            $display("%t %s: expected start=%0b fin=%0b task=%0d busy=%0b next=%0b/%0d",
                     $realtime, what,
                     want.task_started, want.task_finished, want.active_task,
                     want.busy_res, want.next_valid, want.next_slot);
            $display("   got start=%0b fin=%0b task=%0d busy=%0b next=%0b/%0d",
                     got.task_started, got.task_finished, got.active_task,
                     got.busy_res, got.next_valid, got.next_slot);
         end
      endfunction

      function void check_decision(result_type got);
         result_type want;
         if (pending_decisions.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = pending_decisions.pop_front();
         if (got.task_started  !== want.task_started  ||
             got.task_finished !== want.task_finished ||
             got.active_task   !== want.active_task   ||
             got.busy_res      !== want.busy_res      ||
             got.next_valid    !== want.next_valid    ||
             got.next_slot     !== want.next_slot)
            report("mismatch", want, got);
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VOLT_W-1:0]     req_buffer_voltage_mv = '0;
   logic [PWR_W-1:0]      req_harvest_power_uw = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_task_started;
   logic                  rsp_task_finished;
   logic [TASK_W-1:0]     rsp_active_task;
   logic                  rsp_busy_res;
   logic                  rsp_next_valid;
   logic [SLOT_W-1:0]     rsp_next_slot;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   result_type           seen;
   schedule_tracker_type sb;
   int                   cycle_count = 0;
   int                   phase_count = 0;
   stall_mode_type       stall_mode = STALL_NONE;
   int                   stall_age = 0;

   assign seen = {rsp_task_started, rsp_task_finished, rsp_active_task,
                  rsp_busy_res, rsp_next_valid, rsp_next_slot};

   energy_aware_task_scheduler #(.COUNT_BITS(COUNT_W)) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_buffer_voltage_mv (req_buffer_voltage_mv),
      .req_harvest_power_uw  (req_harvest_power_uw),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_task_started      (rsp_task_started),
      .rsp_task_finished     (rsp_task_finished),
      .rsp_active_task       (rsp_active_task),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_next_valid        (rsp_next_valid),
      .rsp_next_slot         (rsp_next_slot),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Receiver back-pressure: the stall mode is re-chosen at random whenever stall_age runs out
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_age = int'($urandom_range(20, 80));
      end else begin
         stall_age--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_LONG:   rsp_stall <= (stall_age % 8) < 5;
         default:      rsp_stall <= ~rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (csr_write_enable) sb.write_reg(csr_index, csr_write_data);
         if (req_valid && !req_stall) sb.note_tick(req_buffer_voltage_mv, req_harvest_power_uw);
         if (rsp_valid && !rsp_stall) sb.check_decision(seen);
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic slot_entry_type make_slot(int thr, int id, int dur);
      slot_entry_type e;
      e.thr     = thr[THR_W-1:0];
      e.task_id = id[TASK_W-1:0];
      e.dur     = dur[DUR_W-1:0];
      return e;
   endfunction

   function automatic slot_entry_type random_slot();
      int thr;
      int dur;
      case ($urandom_range(0, 5))
         0:       thr = 0;
         1:       thr = (1 << THR_W) - 1;
         default: thr = $urandom_range(0, (1 << THR_W) - 1);
      endcase
      dur = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 4);
      return make_slot(thr, $urandom_range(0, TASK_IDS - 1), dur);
   endfunction

   // Half the voltages land right around a slot threshold
   function automatic logic [VOLT_W-1:0] pick_voltage();
      int v;
      if ($urandom_range(0, 1)) return VOLT_W'($urandom_range(0, (1 << VOLT_W) - 1));
      v = int'(sb.slots[$urandom_range(0, SLOTS - 1)].thr) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > (1 << VOLT_W) - 1) v = (1 << VOLT_W) - 1;
      return v[VOLT_W-1:0];
   endfunction

   function automatic logic [PWR_W-1:0] pick_power();
      int p;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: begin
            p = int'(sb.pwr_thr) + int'($urandom_range(0, 4)) - 2;
            if (p < 0) p = 0;
            if (p > (1 << PWR_W) - 1) p = (1 << PWR_W) - 1;
            return p[PWR_W-1:0];
         end
         default: return PWR_W'($urandom_range(0, (1 << PWR_W) - 1));
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic csr_done();
      csr_write_enable <= 1'b0;
      @(posedge clock);
      phase_count++;
   endtask

   // Drives one tick item and returns in the step of the edge that took it
   task automatic send_tick(input logic [VOLT_W-1:0] volt, input logic [PWR_W-1:0] pwr);
      req_valid             <= 1'b1;
      req_buffer_voltage_mv <= volt;
      req_harvest_power_uw  <= pwr;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic end_burst(input int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_ticks(input int count);
      int left;
      int burst;
      int gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         repeat (burst) send_tick(pick_voltage(), pick_power());
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0 || left == 0) end_burst(gap);
      end
   endtask

   task automatic program_random_phase();
      logic [CSR_DATA_W-1:0] thr;
      case ($urandom_range(0, 3))
         0:       thr = '0;
         1:       thr = {{(CSR_DATA_W - PWR_W){1'b0}}, PWR_THR_RESET};
         2:       thr = CSR_DATA_W'($urandom_range(0, 1000));
         default: thr = CSR_DATA_W'($urandom_range(0, (1 << PWR_W) - 1));
      endcase
      csr_write(CSR_POWER_THR, thr);
      csr_write(CSR_TASK_COUNT,
                CSR_DATA_W'(($urandom_range(0, 9) < 6) ? 4 : $urandom_range(0, 7)));
      for (int s = 0; s < SLOTS; s++)
         csr_write(CSR_ADDR_W'(int'(CSR_SLOT0) + s), random_slot());
      if ($urandom_range(0, 3) == 0) csr_write(CSR_PAST_END_A, CSR_DATA_W'($urandom));
      csr_done();
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: only slot 0 in use, threshold 0, zero duration
      phase_count++;
      send_tick('0, '0);
      send_tick('1, '1);
      send_tick(13'd1, '1);
      send_tick('0, '0);
      send_tick('1, '0);
      send_tick(13'd4096, 20'd524288);
      end_burst(0);
      wait_idle();

      // Power hold-back, duplicate task ids, a slot that can never be chosen
      csr_write(CSR_POWER_THR, '0);
      csr_write(CSR_TASK_COUNT, CSR_DATA_W'(4));
      csr_write(CSR_SLOT0, make_slot(8191, 0, 0));
      csr_write(CSR_SLOT1, make_slot(0, 1, 1));
      csr_write(CSR_SLOT2, make_slot(10, 1, 3));
      csr_write(CSR_SLOT3, '1);
      csr_write(CSR_PAST_END_A, '1);
      csr_write(CSR_PAST_END_B, '1);
      csr_done();
      send_tick('1, '1);
      send_tick('1, '0);
      send_tick(13'd5, '0);
      send_tick('0, 20'd1);
      send_tick(13'd10, '0);
      send_tick(13'd11, '0);
      send_tick('1, '0);
      send_tick('0, '0);
      end_burst(0);
      wait_idle();

      // Task count of zero acts as one; a task id past the count is disabled.
      // A task may still be running from the previous settings.
      csr_write(CSR_TASK_COUNT, CSR_DATA_W'(0));
      csr_write(CSR_POWER_THR, {{(CSR_DATA_W - PWR_W){1'b0}}, PWR_THR_RESET});
      csr_write(CSR_SLOT0, make_slot(0, 3, 2));
      csr_done();
      send_tick('1, '1);
      send_tick(13'd100, '0);
      send_tick('0, '0);
      end_burst(0);
      wait_idle();

      // Task count above the maximum acts as the maximum
      csr_write(CSR_TASK_COUNT, CSR_DATA_W'(7));
      csr_write(CSR_SLOT0, make_slot(0, 3, 0));
      csr_write(CSR_SLOT1, make_slot(0, 0, 2));
      csr_done();
      send_tick(13'd1, '1);
      send_tick('1, '0);
      send_tick('0, '0);
      send_tick(13'd4000, 20'd12345);
      end_burst(0);
      wait_idle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         program_random_phase();
         run_ticks(PHASE_TICKS);
         wait_idle();
      end
      repeat (6) @(posedge clock);

      $display("Covered %0d ticks over %0d register settings: %0d task starts, %0d finishes",
               sb.tick_total, phase_count, sb.starts, sb.finishes);
      $display("Slot choices %0d/%0d/%0d/%0d, %0d ticks held back by harvested power",
               sb.picks[0], sb.picks[1], sb.picks[2], sb.picks[3], sb.holds);
      if (sb.pending() != 0)
         $display("%0d expected results never arrived", sb.pending());
      if (sb.errors > 10)
         $display("%0d failures in total", sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
